// File: design/wbps_pkg.sv
package wbps_pkg;

    // Search geometry
    localparam int MAX_PATTERN = 32;
    localparam int OFFSET_BITS = 32;
    localparam int LEN_W       = 6;
    localparam int SEL_W       = $clog2(MAX_PATTERN);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int WORD_BYTES  = CFG_DATA_W / 8;

    localparam logic [7:0]       WILDCARD_RESET = 8'd46;
    localparam logic [LEN_W-1:0] LEN_MAX        = LEN_W'(MAX_PATTERN);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_LENGTH = 3'd0,
        REG_WILDCARD_CODE  = 3'd1,
        REG_PATTERN_WORD_0 = 3'd2,
        REG_PATTERN_WORD_1 = 3'd3,
        REG_PATTERN_WORD_2 = 3'd4,
        REG_PATTERN_WORD_3 = 3'd5
    } reg_idx_t;

    // Byte arrays: element 0 is pattern byte 0 / newest data byte
    typedef logic [MAX_PATTERN-1:0][7:0] byte_row_t;

    typedef struct packed {
        logic [LEN_W-1:0] pattern_length;
        logic [7:0]       wildcard_code;
        byte_row_t        pattern;
    } cfg_t;

    // Input stage contents handed to the comparator
    typedef struct packed {
        byte_row_t              window;
        logic [OFFSET_BITS-1:0] count;
        logic                   last;
    } stage_t;

    typedef struct packed {
        logic                   hit;
        logic [OFFSET_BITS-1:0] offset;
    } match_t;

endpackage

// File: design/wildcard_byte_pattern_search.sv
// Channel  | Handshake            | Payload
// input    | in_valid / in_ready  | data_byte, last_byte
// result   | out_valid / out_ready| found, match_offset
// config   | cfg_write            | cfg_index, cfg_data
//
// One byte per cycle while the result register is free; a byte goes into the
// input stage (byte window and count), then through the full-window compare
// into the result register, which drives the result ports.
// Reset clears the count, region and result-valid state, and loads the defaults.
// A result held by out_ready low stalls the input stage, then in_ready.
module wildcard_byte_pattern_search import wbps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             data_byte,
    input  logic                   last_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   found,
    output logic [OFFSET_BITS-1:0] match_offset,
    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t   cfg;
    stage_t stage;
    match_t result;

    logic stage_valid_reg, stage_valid_next;
    logic reported_reg, reported_next;
    logic out_valid_reg, out_valid_next;
    logic found_reg, found_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic in_xfer, advance, emit;

    wbps_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    wbps_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_xfer),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .stage     (stage)
    );

    wbps_match u_match (
        .cfg    (cfg),
        .stage  (stage),
        .result (result)
    );

    // Handshake: stage moves on when the result register is free
    assign advance  = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    // Result decision and region tracking
    always_comb
    begin
        emit          = !reported_reg && (result.hit || stage.last);
        reported_next = reported_reg;
        if (advance)
        begin
            if (stage.last)
                reported_next = 1'b0;
            else if (result.hit)
                reported_next = 1'b1;
        end

        stage_valid_next = in_xfer ? 1'b1 : (advance ? 1'b0 : stage_valid_reg);

        out_valid_next = out_valid_reg && !out_ready;
        found_next     = found_reg;
        offset_next    = offset_reg;
        if (advance && emit)
        begin
            out_valid_next = 1'b1;
            found_next     = result.hit;
            offset_next    = result.hit ? result.offset : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            reported_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            reported_reg    <= reported_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        found_reg  <= found_next;
        offset_reg <= offset_next;
    end

    assign out_valid    = out_valid_reg;
    assign found        = found_reg;
    assign match_offset = offset_reg;

endmodule

// File: design/wbps_cfg.sv
module wbps_cfg import wbps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [LEN_W-1:0] length_reg;
    logic [7:0]       wildcard_reg;
    byte_row_t        pattern_reg;

    // Register file, writes only; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg   <= '0;
            wildcard_reg <= WILDCARD_RESET;
            pattern_reg  <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PATTERN_LENGTH: length_reg   <= cfg_data[LEN_W-1:0];
                REG_WILDCARD_CODE:  wildcard_reg <= cfg_data[7:0];
                REG_PATTERN_WORD_0: pattern_reg[0*WORD_BYTES +: WORD_BYTES] <= cfg_data;
                REG_PATTERN_WORD_1: pattern_reg[1*WORD_BYTES +: WORD_BYTES] <= cfg_data;
                REG_PATTERN_WORD_2: pattern_reg[2*WORD_BYTES +: WORD_BYTES] <= cfg_data;
                REG_PATTERN_WORD_3: pattern_reg[3*WORD_BYTES +: WORD_BYTES] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg.pattern_length = length_reg;
    assign cfg.wildcard_code  = wildcard_reg;
    assign cfg.pattern        = pattern_reg;

endmodule

// File: design/wbps_window.sv
module wbps_window import wbps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output stage_t     stage
);

    byte_row_t              window_reg;
    logic [OFFSET_BITS-1:0] count_reg;
    logic [OFFSET_BITS-1:0] count_next;
    logic [OFFSET_BITS-1:0] count_base;
    logic                   last_reg;

    // Count restarts after a region's last byte, saturates at all ones
    always_comb
    begin
        count_base = last_reg ? '0 : count_reg;
        count_next = (&count_base) ? count_base : count_base + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            last_reg  <= 1'b0;
        end
        else if (load)
        begin
            count_reg <= count_next;
            last_reg  <= last_byte;
        end
    end

    // Byte shift line, newest at element 0
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            window_reg <= {window_reg[MAX_PATTERN-2:0], data_byte};
        end
    end

    assign stage.window = window_reg;
    assign stage.count  = count_reg;
    assign stage.last   = last_reg;

endmodule

// File: design/wbps_match.sv
module wbps_match import wbps_pkg::*;
(
    input  cfg_t   cfg,
    input  stage_t stage,
    output match_t result
);

    logic [LEN_W-1:0]       len;
    logic [MAX_PATTERN-1:0] byte_ok;
    logic [SEL_W-1:0]       sel;
    logic [7:0]             pat;
    logic                   enough;

    // Parallel compare of the newest len bytes against the pattern
    always_comb
    begin
        len = (cfg.pattern_length > LEN_MAX) ? LEN_MAX : cfg.pattern_length;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            pat = cfg.pattern[i];
            sel = SEL_W'(len - LEN_W'(i) - 1'b1);
            byte_ok[i] = (LEN_W'(i) >= len) || (pat == cfg.wildcard_code)
                         || (pat == stage.window[sel]);
        end
        enough        = stage.count >= OFFSET_BITS'(len);
        result.hit    = (len != '0) && enough && (&byte_ok);
        result.offset = stage.count - OFFSET_BITS'(len);
    end

endmodule

// File: design/wbps_checker.sv
module wbps_checker import wbps_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic                   found,
    input logic [OFFSET_BITS-1:0] match_offset
);

    // A stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found) && $stable(match_offset))
    else $error("result changed while stalled");

    // A no-match result carries a zero offset
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> match_offset == '0)
    else $error("no-match result with nonzero offset");

    // Input only backs up behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a held result");

    // One byte in flight can be absorbed when the output drains
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
    else $error("input not ready while output drains");

endmodule

bind wildcard_byte_pattern_search wbps_checker u_wbps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .match_offset (match_offset)
);
